// ===== src/lit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lit_pkg - shared types and constants for the line index table
// Sizes, operation and status codes, cell update codes and the structs that
// run between the top level and the row of table cells.
// ----------------------------------------------------------------------------
package lit_pkg;

  localparam int MAX_LINES   = 256;
  localparam int OFFSET_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_LINES);
  localparam int CNT_W       = $clog2(MAX_LINES + 1);
  localparam int POS_W       = 16;
  localparam int CHAR_W      = 8;
  localparam int LI_W        = 8;
  localparam int WIDE_W      = ((OFFSET_BITS > POS_W) ? OFFSET_BITS : POS_W) + 1;
  localparam int CMP_W       = (LI_W > CNT_W) ? LI_W : CNT_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef logic [2:0] code_t;

  // edited line itself
  localparam code_t CUR_KEEP    = 3'd0;
  localparam code_t CUR_INC     = 3'd1;
  localparam code_t CUR_INC_NL  = 3'd2;
  localparam code_t CUR_SPLIT   = 3'd3;
  localparam code_t CUR_DEC     = 3'd4;
  localparam code_t CUR_DEC_CLR = 3'd5;
  localparam code_t CUR_MERGE   = 3'd6;

  // line just after the edited one
  localparam code_t NXT_KEEP      = 3'd0;
  localparam code_t NXT_INC_OFF   = 3'd1;
  localparam code_t NXT_INC_LEN   = 3'd2;
  localparam code_t NXT_NEW_END   = 3'd3;
  localparam code_t NXT_NEW_SPLIT = 3'd4;
  localparam code_t NXT_PULL      = 3'd5;
  localparam code_t NXT_DEC_OFF   = 3'd6;

  // all lines further on
  localparam code_t FAR_KEEP = 3'd0;
  localparam code_t FAR_INC  = 3'd1;
  localparam code_t FAR_PUSH = 3'd2;
  localparam code_t FAR_PULL = 3'd3;
  localparam code_t FAR_DEC  = 3'd4;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] len;
    logic                   nl;
  } entry_t;

  typedef struct packed {
    logic              rem;
    logic [WIDE_W-1:0] pos;
    logic [IDX_W-1:0]  sel;
    logic [CNT_W-1:0]  total;
  } probe_req_t;

  typedef struct packed {
    logic hit;
    logic hit_end;
    logic hit_tail;
    logic hit_nl;
  } probe_t;

  typedef struct packed {
    logic              apply;
    logic [CNT_W-1:0]  idx;
    logic [CNT_W-1:0]  idx_nxt;
    code_t             cur;
    code_t             nxt;
    code_t             far;
    logic [WIDE_W-1:0] pos;
    logic              nl_char;
  } edit_t;

endpackage
`default_nettype wire

// ===== src/lit_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lit_cell - one line entry of the table
// Holds offset, length and newline flag of one line, matches the probed
// position against it and updates or shifts from its neighbours on an edit.
// ----------------------------------------------------------------------------
module lit_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [lit_pkg::IDX_W-1:0] cell_index,
  input  wire lit_pkg::entry_t           left,
  input  wire lit_pkg::entry_t           right,
  input  wire logic                      left_match,
  input  wire lit_pkg::probe_req_t       req,
  input  wire lit_pkg::edit_t            edit,
  output lit_pkg::entry_t                entry,
  output logic                           match,
  output lit_pkg::probe_t                probe,
  output lit_pkg::entry_t                read_data
);

  lit_pkg::entry_t                    entry_next;
  logic [lit_pkg::CNT_W-1:0]          idx_w;
  logic                               in_use;
  logic [lit_pkg::WIDE_W-1:0]         off_w;
  logic [lit_pkg::WIDE_W-1:0]         end_w;
  logic [lit_pkg::OFFSET_BITS-1:0]    pos_o;
  logic                               is_cur;
  logic                               is_nxt;
  logic                               is_far;

  assign idx_w  = lit_pkg::CNT_W'(cell_index);
  assign in_use = idx_w < req.total;
  assign off_w  = lit_pkg::WIDE_W'(entry.off);
  assign end_w  = off_w + lit_pkg::WIDE_W'(entry.len);

  always_comb begin
    if (req.rem) begin
      match = in_use && (req.pos >= off_w) && (req.pos < end_w);
    end else begin
      match = in_use && (req.pos >= off_w) && (req.pos <= end_w);
    end
  end

  assign probe.hit      = match && !left_match;
  assign probe.hit_end  = probe.hit && (req.pos == end_w);
  assign probe.hit_tail = probe.hit && ((req.pos + lit_pkg::WIDE_W'(1)) == end_w);
  assign probe.hit_nl   = probe.hit && entry.nl;

  assign read_data = (cell_index == req.sel) ? entry : '0;

  assign pos_o  = lit_pkg::OFFSET_BITS'(edit.pos);
  assign is_cur = idx_w == edit.idx;
  assign is_nxt = idx_w == edit.idx_nxt;
  assign is_far = idx_w > edit.idx_nxt;

  always_comb begin
    entry_next = entry;
    if (edit.apply) begin
      if (is_cur) begin
        unique case (edit.cur)
          lit_pkg::CUR_INC: begin
            entry_next.len = entry.len + 1'b1;
          end
          lit_pkg::CUR_INC_NL: begin
            entry_next.len = entry.len + 1'b1;
            entry_next.nl  = 1'b1;
          end
          lit_pkg::CUR_SPLIT: begin
            entry_next.len = pos_o - entry.off + 1'b1;
            entry_next.nl  = 1'b1;
          end
          lit_pkg::CUR_DEC: begin
            entry_next.len = entry.len - 1'b1;
          end
          lit_pkg::CUR_DEC_CLR: begin
            entry_next.len = entry.len - 1'b1;
            entry_next.nl  = 1'b0;
          end
          lit_pkg::CUR_MERGE: begin
            entry_next.len = entry.len + right.len - 1'b1;
            entry_next.nl  = right.nl;
          end
          default: begin
            entry_next = entry;
          end
        endcase
      end else if (is_nxt) begin
        unique case (edit.nxt)
          lit_pkg::NXT_INC_OFF: begin
            entry_next.off = entry.off + 1'b1;
          end
          lit_pkg::NXT_INC_LEN: begin
            entry_next.len = entry.len + 1'b1;
          end
          lit_pkg::NXT_NEW_END: begin
            entry_next.off = pos_o;
            entry_next.len = lit_pkg::OFFSET_BITS'(1);
            entry_next.nl  = edit.nl_char;
          end
          lit_pkg::NXT_NEW_SPLIT: begin
            entry_next.off = pos_o + 1'b1;
            entry_next.len = left.len - (pos_o - left.off);
            entry_next.nl  = left.nl;
          end
          lit_pkg::NXT_PULL: begin
            entry_next     = right;
            entry_next.off = right.off - 1'b1;
          end
          lit_pkg::NXT_DEC_OFF: begin
            entry_next.off = entry.off - 1'b1;
          end
          default: begin
            entry_next = entry;
          end
        endcase
      end else if (is_far) begin
        unique case (edit.far)
          lit_pkg::FAR_INC: begin
            entry_next.off = entry.off + 1'b1;
          end
          lit_pkg::FAR_PUSH: begin
            entry_next     = left;
            entry_next.off = left.off + 1'b1;
          end
          lit_pkg::FAR_PULL: begin
            entry_next     = right;
            entry_next.off = right.off - 1'b1;
          end
          lit_pkg::FAR_DEC: begin
            entry_next.off = entry.off - 1'b1;
          end
          default: begin
            entry_next = entry;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/line_index_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_index_table_unit - ordered table of text line entries
// Inserts and removes single characters, splitting and merging lines, and
// reads back one line entry per transaction.
// ----------------------------------------------------------------------------
// Each transaction runs through a probe cycle, in which every cell of the
// row compares the position against its own line at once, and an apply cycle,
// in which the owning cell and all later cells update or shift by one place
// from their neighbours. The next transaction is taken in the apply cycle, so
// a new transaction overlaps the apply cycle of the last one while the result
// register drains; a held result holds the apply cycle. After reset the table
// holds one empty line without a newline.
// ----------------------------------------------------------------------------
module line_index_table_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] position,
  input  wire logic [7:0]  char_code,
  input  wire logic [7:0]  line_index,
  input  wire logic        last_in_run,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       status,
  output logic [8:0]       line_count,
  output logic [15:0]      text_length,
  output logic [15:0]      entry_offset,
  output logic [15:0]      entry_length,
  output logic             entry_has_newline,
  output logic             change_done
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIND  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [1:0]                      op_q;
  logic [lit_pkg::POS_W-1:0]       pos_q;
  logic [lit_pkg::CHAR_W-1:0]      ch_q;
  logic [lit_pkg::LI_W-1:0]        li_q;
  logic                            last_q;

  logic                            found_q;
  logic [lit_pkg::IDX_W-1:0]       idx_q;
  logic                            end_q;
  logic                            tail_q;
  logic                            nl_q;
  lit_pkg::entry_t                 rd_q;

  logic [lit_pkg::CNT_W-1:0]       line_total;
  logic [lit_pkg::CNT_W-1:0]       line_total_next;
  logic [lit_pkg::OFFSET_BITS-1:0] char_total;
  logic [lit_pkg::OFFSET_BITS-1:0] char_total_next;

  lit_pkg::entry_t                 entries   [lit_pkg::MAX_LINES];
  lit_pkg::entry_t                 left_in   [lit_pkg::MAX_LINES];
  lit_pkg::entry_t                 right_in  [lit_pkg::MAX_LINES];
  lit_pkg::entry_t                 read_data [lit_pkg::MAX_LINES];
  lit_pkg::probe_t                 probes    [lit_pkg::MAX_LINES];
  logic [lit_pkg::MAX_LINES-1:0]   match_vec;
  logic [lit_pkg::MAX_LINES-1:0]   left_m;
  logic [lit_pkg::MAX_LINES-1:0]   hits;

  lit_pkg::probe_req_t             req;
  lit_pkg::edit_t                  edit;

  logic                            found_any;
  logic [lit_pkg::IDX_W-1:0]       idx_enc;
  logic                            end_any;
  logic                            tail_any;
  logic                            nl_any;
  lit_pkg::entry_t                 rd_any;

  logic                            accept;
  logic                            apply_fire;
  logic [lit_pkg::WIDE_W-1:0]      pos_w;
  logic [lit_pkg::WIDE_W-1:0]      chars_w;
  logic                            c_nl;
  logic                            char_full;
  logic                            table_full;
  logic                            is_last;
  logic                            grows;
  logic                            read_ok;
  logic [1:0]                      status_next;
  logic                            edit_ok;
  lit_pkg::code_t                  cur_code;
  lit_pkg::code_t                  nxt_code;
  lit_pkg::code_t                  far_code;

  // --- row of cells ---------------------------------------------------------
  genvar g;
  for (g = 0; g < lit_pkg::MAX_LINES; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = '0;
      assign left_m[g]  = 1'b0;
    end else begin : g_inner
      assign left_in[g] = entries[g-1];
      assign left_m[g]  = match_vec[g-1];
    end
    if (g == lit_pkg::MAX_LINES - 1) begin : g_last
      assign right_in[g] = '0;
    end else begin : g_body
      assign right_in[g] = entries[g+1];
    end

    lit_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (lit_pkg::IDX_W'(g)),
      .left       (left_in[g]),
      .right      (right_in[g]),
      .left_match (left_m[g]),
      .req        (req),
      .edit       (edit),
      .entry      (entries[g]),
      .match      (match_vec[g]),
      .probe      (probes[g]),
      .read_data  (read_data[g])
    );

    assign hits[g] = probes[g].hit;
  end

  assign req.rem   = op_q == lit_pkg::OP_REMOVE;
  assign req.pos   = lit_pkg::WIDE_W'(pos_q);
  assign req.sel   = lit_pkg::IDX_W'(li_q);
  assign req.total = line_total;

  always_comb begin
    found_any = 1'b0;
    idx_enc   = '0;
    end_any   = 1'b0;
    tail_any  = 1'b0;
    nl_any    = 1'b0;
    rd_any    = '0;
    for (int i = 0; i < lit_pkg::MAX_LINES; i++) begin
      found_any = found_any | probes[i].hit;
      idx_enc   = idx_enc | (probes[i].hit ? lit_pkg::IDX_W'(i) : '0);
      end_any   = end_any | probes[i].hit_end;
      tail_any  = tail_any | probes[i].hit_tail;
      nl_any    = nl_any | probes[i].hit_nl;
      rd_any    = rd_any | read_data[i];
    end
  end

  // --- sequencing -----------------------------------------------------------
  assign apply_fire = (state == S_APPLY) && (!result_valid || !result_stall);
  assign item_stall = !((state == S_IDLE) || apply_fire);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (apply_fire) begin
          state_next = accept ? S_FIND : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      pos_q  <= position;
      ch_q   <= char_code;
      li_q   <= line_index;
      last_q <= last_in_run;
    end
    if (state == S_FIND) begin
      found_q <= found_any;
      idx_q   <= idx_enc;
      end_q   <= end_any;
      tail_q  <= tail_any;
      nl_q    <= nl_any;
      rd_q    <= rd_any;
    end
  end

  // --- apply decision -------------------------------------------------------
  assign pos_w      = lit_pkg::WIDE_W'(pos_q);
  assign chars_w    = lit_pkg::WIDE_W'(char_total);
  assign c_nl       = ch_q == lit_pkg::NEWLINE_CODE;
  assign char_full  = char_total == '1;
  assign table_full = line_total >= lit_pkg::CNT_W'(lit_pkg::MAX_LINES);
  assign is_last    = (lit_pkg::CNT_W'(idx_q) + lit_pkg::CNT_W'(1)) == line_total;
  assign grows      = end_q ? (nl_q && (c_nl || is_last)) : c_nl;
  assign read_ok    = lit_pkg::CMP_W'(li_q) < lit_pkg::CMP_W'(line_total);

  always_comb begin
    status_next     = lit_pkg::ST_OK;
    edit_ok         = 1'b0;
    cur_code        = lit_pkg::CUR_KEEP;
    nxt_code        = lit_pkg::NXT_KEEP;
    far_code        = lit_pkg::FAR_KEEP;
    line_total_next = line_total;
    char_total_next = char_total;
    unique case (op_q)
      lit_pkg::OP_INSERT: begin
        priority if (pos_w > chars_w) begin
          status_next = lit_pkg::ST_BAD_POS;
        end else if (char_full) begin
          status_next = lit_pkg::ST_FULL;
        end else if (!found_q) begin
          status_next = lit_pkg::ST_BAD_POS;
        end else if (grows && table_full) begin
          status_next = lit_pkg::ST_FULL;
        end else begin
          edit_ok         = 1'b1;
          char_total_next = char_total + 1'b1;
          priority if (end_q && nl_q && (c_nl || is_last)) begin
            nxt_code        = lit_pkg::NXT_NEW_END;
            far_code        = lit_pkg::FAR_PUSH;
            line_total_next = line_total + 1'b1;
          end else if (end_q && nl_q) begin
            nxt_code = lit_pkg::NXT_INC_LEN;
            far_code = lit_pkg::FAR_INC;
          end else if (end_q && c_nl) begin
            cur_code = lit_pkg::CUR_INC_NL;
            nxt_code = lit_pkg::NXT_INC_OFF;
            far_code = lit_pkg::FAR_INC;
          end else if (!end_q && c_nl) begin
            cur_code        = lit_pkg::CUR_SPLIT;
            nxt_code        = lit_pkg::NXT_NEW_SPLIT;
            far_code        = lit_pkg::FAR_PUSH;
            line_total_next = line_total + 1'b1;
          end else begin
            cur_code = lit_pkg::CUR_INC;
            nxt_code = lit_pkg::NXT_INC_OFF;
            far_code = lit_pkg::FAR_INC;
          end
        end
      end
      lit_pkg::OP_REMOVE: begin
        priority if (pos_w >= chars_w) begin
          status_next = lit_pkg::ST_BAD_POS;
        end else if (!found_q) begin
          status_next = lit_pkg::ST_BAD_POS;
        end else begin
          edit_ok         = 1'b1;
          char_total_next = char_total - 1'b1;
          priority if (tail_q && nl_q && is_last) begin
            cur_code = lit_pkg::CUR_DEC_CLR;
            nxt_code = lit_pkg::NXT_DEC_OFF;
            far_code = lit_pkg::FAR_DEC;
          end else if (tail_q && nl_q) begin
            cur_code        = lit_pkg::CUR_MERGE;
            nxt_code        = lit_pkg::NXT_PULL;
            far_code        = lit_pkg::FAR_PULL;
            line_total_next = line_total - 1'b1;
          end else begin
            cur_code = lit_pkg::CUR_DEC;
            nxt_code = lit_pkg::NXT_DEC_OFF;
            far_code = lit_pkg::FAR_DEC;
          end
        end
      end
      lit_pkg::OP_READ: begin
        if (!read_ok) begin
          status_next = lit_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        status_next = lit_pkg::ST_OK;
      end
    endcase
  end

  assign edit.apply   = apply_fire && edit_ok;
  assign edit.idx     = lit_pkg::CNT_W'(idx_q);
  assign edit.idx_nxt = lit_pkg::CNT_W'(idx_q) + lit_pkg::CNT_W'(1);
  assign edit.cur     = cur_code;
  assign edit.nxt     = nxt_code;
  assign edit.far     = far_code;
  assign edit.pos     = pos_w;
  assign edit.nl_char = c_nl;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_total <= lit_pkg::CNT_W'(1);
      char_total <= '0;
    end else if (edit.apply) begin
      line_total <= line_total_next;
      char_total <= char_total_next;
    end
  end

  // --- result register ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (apply_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      status      <= status_next;
      line_count  <= 9'(edit_ok ? line_total_next : line_total);
      text_length <= 16'(edit_ok ? char_total_next : char_total);
      if ((op_q == lit_pkg::OP_READ) && read_ok) begin
        entry_offset      <= 16'(rd_q.off);
        entry_length      <= 16'(rd_q.len);
        entry_has_newline <= rd_q.nl;
      end else begin
        entry_offset      <= '0;
        entry_length      <= '0;
        entry_has_newline <= 1'b0;
      end
      change_done <= ((op_q == lit_pkg::OP_INSERT) || (op_q == lit_pkg::OP_REMOVE))
                     && last_q;
    end
  end

  // --- checks ---------------------------------------------------------------
  a_single_owner : assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> $onehot0(hits))
    else $error("more than one cell owns the probed position");

  a_result_from_apply : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_APPLY))
    else $error("result raised outside the apply cycle");

  a_fail_no_change : assert property (@(posedge clk) disable iff (rst)
    (apply_fire && (status_next != lit_pkg::ST_OK))
      |=> ($stable(line_total) && $stable(char_total)))
    else $error("failed transaction changed the table counts");

  a_line_total_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> ((line_total != '0)
      && (line_total <= lit_pkg::CNT_W'(lit_pkg::MAX_LINES))))
    else $error("line count out of range");

endmodule
`default_nettype wire

// ===== test/line_index_table_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_index_table_unit_tb - self-checking bench for the line index table
// Sends inserts, removes and reads through the valid/stall handshake, with
// random gaps on both sides. A behavioural copy of the line table predicts
// each result transaction, and every result is checked in order, field by
// field. Covers splits, merges and a full table.
// ----------------------------------------------------------------------------
module line_index_table_unit_tb;
  import lit_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int CHAR_LIMIT   = (1 << OFFSET_BITS) - 1;
  localparam int DOC_SOFT_MAX = 300;
  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_EVERY  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  line_count;
    logic [15:0] text_length;
    logic [15:0] entry_offset;
    logic [15:0] entry_length;
    logic        entry_has_newline;
    logic        change_done;
  } line_result_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  logic [1:0]  operation    = '0;
  logic [15:0] position     = '0;
  logic [7:0]  char_code    = '0;
  logic [7:0]  line_index   = '0;
  logic        last_in_run  = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  status;
  logic [8:0]  line_count;
  logic [15:0] text_length;
  logic [15:0] entry_offset;
  logic [15:0] entry_length;
  logic        entry_has_newline;
  logic        change_done;

  // behavioural copy of the line table
  entry_t       doc_line [MAX_LINES];
  int           doc_lines;
  int           doc_chars;
  line_result_t pending_results [$];
  line_result_t oldest;
  int           fail_count  = 0;
  int           cycle_count = 0;
  int           stall_left  = 0;
  bit           gaps_on     = 1'b1;

  line_index_table_unit i_dut (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .operation         (operation),
    .position          (position),
    .char_code         (char_code),
    .line_index        (line_index),
    .last_in_run       (last_in_run),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .status            (status),
    .line_count        (line_count),
    .text_length       (text_length),
    .entry_offset      (entry_offset),
    .entry_length      (entry_length),
    .entry_has_newline (entry_has_newline),
    .change_done       (change_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(9, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic void table_reset();
    doc_line[0] = '0;
    doc_lines   = 1;
    doc_chars   = 0;
  endfunction

  function automatic void open_line(int at, int off, int len, logic nl);
    for (int j = doc_lines; j > at; j--)
      doc_line[j] = doc_line[j-1];
    doc_line[at].off = OFFSET_BITS'(off);
    doc_line[at].len = OFFSET_BITS'(len);
    doc_line[at].nl  = nl;
    doc_lines++;
  endfunction

  function automatic void close_line(int at);
    for (int j = at; j < doc_lines - 1; j++)
      doc_line[j] = doc_line[j+1];
    doc_lines--;
  endfunction

  function automatic logic [1:0] insert_char(int pos, logic [7:0] ch);
    int idx;
    int from;
    int part;
    bit found;
    bit at_end;
    bit grows;
    idx   = 0;
    found = 1'b0;
    if (pos > doc_chars) return ST_BAD_POS;
    if (doc_chars >= CHAR_LIMIT) return ST_FULL;
    for (int i = 0; i < doc_lines; i++)
      if (!found && pos >= int'(doc_line[i].off) &&
          pos <= int'(doc_line[i].off) + int'(doc_line[i].len)) begin
        idx   = i;
        found = 1'b1;
      end
    if (!found) return ST_BAD_POS;
    at_end = (pos == int'(doc_line[idx].off) + int'(doc_line[idx].len));
    if (at_end)
      grows = doc_line[idx].nl && (ch == NEWLINE_CODE || idx == doc_lines - 1);
    else
      grows = (ch == NEWLINE_CODE);
    if (grows && doc_lines >= MAX_LINES) return ST_FULL;

    if (at_end) begin
      if (ch == NEWLINE_CODE) begin
        if (doc_line[idx].nl) begin
          open_line(idx + 1, pos, 1, 1'b1);
          from = idx + 2;
        end else begin
          doc_line[idx].nl  = 1'b1;
          doc_line[idx].len = doc_line[idx].len + 1'b1;
          from = idx + 1;
        end
      end else if (doc_line[idx].nl) begin
        if (idx == doc_lines - 1)
          open_line(idx + 1, pos, 1, 1'b0);
        else
          doc_line[idx+1].len = doc_line[idx+1].len + 1'b1;
        from = idx + 2;
      end else begin
        doc_line[idx].len = doc_line[idx].len + 1'b1;
        from = idx + 1;
      end
    end else if (ch == NEWLINE_CODE) begin
      part = pos - int'(doc_line[idx].off);
      open_line(idx + 1, pos + 1, int'(doc_line[idx].len) - part, doc_line[idx].nl);
      doc_line[idx].nl  = 1'b1;
      doc_line[idx].len = OFFSET_BITS'(part + 1);
      from = idx + 2;
    end else begin
      doc_line[idx].len = doc_line[idx].len + 1'b1;
      from = idx + 1;
    end
    for (int i = from; i < doc_lines; i++)
      doc_line[i].off = doc_line[i].off + 1'b1;
    doc_chars++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] remove_char(int pos);
    int idx;
    bit found;
    idx   = 0;
    found = 1'b0;
    if (pos >= doc_chars) return ST_BAD_POS;
    for (int i = 0; i < doc_lines; i++)
      if (!found && pos >= int'(doc_line[i].off) &&
          pos < int'(doc_line[i].off) + int'(doc_line[i].len)) begin
        idx   = i;
        found = 1'b1;
      end
    if (!found) return ST_BAD_POS;
    if (pos == int'(doc_line[idx].off) + int'(doc_line[idx].len) - 1 && doc_line[idx].nl) begin
      if (idx == doc_lines - 1) begin
        doc_line[idx].nl  = 1'b0;
        doc_line[idx].len = doc_line[idx].len - 1'b1;
      end else begin
        doc_line[idx].nl  = doc_line[idx+1].nl;
        doc_line[idx].len = OFFSET_BITS'(int'(doc_line[idx].len) +
                                         int'(doc_line[idx+1].len) - 1);
        close_line(idx + 1);
      end
    end else begin
      doc_line[idx].len = doc_line[idx].len - 1'b1;
    end
    for (int i = idx + 1; i < doc_lines; i++)
      doc_line[i].off = doc_line[i].off - 1'b1;
    doc_chars--;
    return ST_OK;
  endfunction

  function automatic line_result_t predict_result(logic [1:0] op, logic [15:0] pos,
                                                  logic [7:0] ch, logic [7:0] li,
                                                  logic last);
    line_result_t r;
    r = '0;
    case (op)
      OP_INSERT: begin
        r.status      = insert_char(int'(pos), ch);
        r.change_done = last;
      end
      OP_REMOVE: begin
        r.status      = remove_char(int'(pos));
        r.change_done = last;
      end
      OP_READ: begin
        if (int'(li) < doc_lines) begin
          r.entry_offset      = doc_line[li].off;
          r.entry_length      = doc_line[li].len;
          r.entry_has_newline = doc_line[li].nl;
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
      default: ;
    endcase
    r.line_count  = 9'(doc_lines);
    r.text_length = 16'(doc_chars);
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with none outstanding", $time);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", 16'(oldest.status), 16'(status));
        check_field("line_count", 16'(oldest.line_count), 16'(line_count));
        check_field("text_length", oldest.text_length, text_length);
        check_field("entry_offset", oldest.entry_offset, entry_offset);
        check_field("entry_length", oldest.entry_length, entry_length);
        check_field("entry_has_newline", 16'(oldest.entry_has_newline),
                    16'(entry_has_newline));
        check_field("change_done", 16'(oldest.change_done), 16'(change_done));
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [15:0] pos, logic [7:0] ch,
                           logic [7:0] li, logic last);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid  <= 1'b1;
    operation   <= op;
    position    <= pos;
    char_code   <= ch;
    line_index  <= li;
    last_in_run <= last;
    do @(posedge clk); while (item_stall);
    pending_results.push_back(predict_result(op, pos, ch, li, last));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_edits();
    send_item(OP_READ,   16'hFFFF, 8'hFF, 8'd0,   1'b1);
    send_item(OP_READ,   16'd0,    8'd0,  8'd1,   1'b0);
    send_item(OP_READ,   16'd0,    8'd0,  8'd255, 1'b0);
    send_item(OP_REMOVE, 16'd0,    8'd0,  8'd0,   1'b1);
    send_item(OP_INSERT, 16'd1,    8'd65, 8'd0,   1'b1);
    send_item(OP_INSERT, 16'hFFFF, 8'd0,  8'd0,   1'b0);
    send_item(OP_INSERT, 16'd0,    8'hFF, 8'd0,   1'b0);
    // newline at the end of a line without one
    send_item(OP_INSERT, 16'd1, NEWLINE_CODE, 8'd0, 1'b0);
    // plain byte after the final newline opens a line
    send_item(OP_INSERT, 16'd2, 8'd0, 8'd255, 1'b1);
    // newline inside a line splits it
    send_item(OP_INSERT, 16'd1, NEWLINE_CODE, 8'd0, 1'b0);
    // newline at the end of a line that has one adds an empty line
    send_item(OP_INSERT, 16'd2, NEWLINE_CODE, 8'd0, 1'b0);
    // plain byte at the end of a newline line that is not the last
    send_item(OP_INSERT, 16'd2, 8'h41, 8'd0, 1'b1);
    send_item(OP_UNUSED, 16'd0, 8'd0, 8'd0, 1'b1);
    for (int i = 0; i <= doc_lines; i++)
      send_item(OP_READ, 16'd0, 8'd0, 8'(i), 1'b0);
    // final newline added and removed again
    send_item(OP_INSERT, 16'(doc_chars), NEWLINE_CODE, 8'd0, 1'b1);
    send_item(OP_REMOVE, 16'(doc_chars - 1), 8'd0, 8'd0, 1'b1);
    // removing a newline merges two lines
    send_item(OP_REMOVE, 16'd1, 8'd0, 8'd0, 1'b0);
    send_item(OP_REMOVE, 16'd0, 8'd0, 8'd0, 1'b1);
    send_item(OP_REMOVE, 16'hFFFF, 8'd0, 8'd0, 1'b1);
    send_item(OP_READ, 16'd0, 8'd0, 8'd0, 1'b0);
    send_item(OP_READ, 16'd0, 8'd0, 8'd1, 1'b0);
  endtask

  task automatic test_random_edits();
    int sent;
    int next_drain;
    int kind;
    int run_len;
    int pos;
    bit backspace;
    logic [7:0] ch;
    sent       = 0;
    next_drain = DRAIN_EVERY;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_EVERY;
      end
      kind    = $urandom_range(0, 99);
      run_len = $urandom_range(1, 8);
      if (kind < 45 && doc_chars > DOC_SOFT_MAX) kind = 50;
      if (kind < 45) begin
        pos = $urandom_range(0, doc_chars);
        for (int k = 0; k < run_len; k++) begin
          ch = ($urandom_range(0, 3) == 0) ? NEWLINE_CODE : 8'($urandom);
          send_item(OP_INSERT, 16'(pos), ch, 8'($urandom), k == run_len - 1);
          pos++;
        end
      end else if (kind < 70) begin
        pos       = $urandom_range(0, doc_chars);
        backspace = $urandom_range(0, 1);
        for (int k = 0; k < run_len; k++) begin
          send_item(OP_REMOVE, 16'(pos), 8'($urandom), 8'($urandom), k == run_len - 1);
          if (backspace && pos > 0) pos--;
        end
      end else if (kind < 88) begin
        for (int k = 0; k < run_len; k++)
          send_item(OP_READ, 16'($urandom), 8'($urandom),
                    8'($urandom_range(0, doc_lines - 1)), 1'($urandom));
      end else begin
        run_len = 1;
        send_item(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
      sent += run_len;
    end
  endtask

  task automatic test_line_table_full();
    int at;
    gaps_on = 1'b1;
    send_item(OP_INSERT, 16'(doc_chars), NEWLINE_CODE, 8'd0, 1'b0);
    while (doc_lines < MAX_LINES)
      send_item(OP_INSERT, 16'($urandom_range(0, doc_chars)), NEWLINE_CODE,
                8'($urandom), doc_lines == MAX_LINES - 1);
    send_item(OP_INSERT, 16'd0, NEWLINE_CODE, 8'd0, 1'b1);
    send_item(OP_INSERT, 16'(doc_chars), 8'h78, 8'd0, 1'b1);
    send_item(OP_INSERT, 16'd0, 8'h78, 8'd0, 1'b1);
    send_item(OP_READ, 16'd0, 8'd0, 8'd255, 1'b0);
    send_item(OP_REMOVE, 16'(doc_chars - 1), 8'd0, 8'd0, 1'b1);
    send_item(OP_INSERT, 16'(doc_chars), 8'h79, 8'd0, 1'b1);
    at = int'(doc_line[10].off) + int'(doc_line[10].len) - 1;
    send_item(OP_REMOVE, 16'(at), 8'd0, 8'd0, 1'b1);
    send_item(OP_INSERT, 16'd3, NEWLINE_CODE, 8'd0, 1'b1);
    send_item(OP_READ, 16'd0, 8'd0, 8'd255, 1'b0);
  endtask

  initial begin
    table_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_edits();
    test_random_edits();
    wait_drained();
    test_line_table_full();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lit_pkg.sv
src/lit_cell.sv
src/line_index_table_unit.sv
test/line_index_table_unit_tb.sv
